// ===== rtl/core/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// Shared codes, constants, types and helpers of the sensor poll engine.
// ----------------------------------------------------------------------------
package msp_pkg;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_END   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_HEADER = 2'd2
  } status_t;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam int RX_BUFFER_BYTES_DEF = 32;
  localparam int QUEUE_DEPTH_DEF     = 2;

  localparam logic [7:0] FUNC_READ_HOLD = 8'h03;
  localparam logic [7:0] REG_ADDR_HI    = 8'h00;
  localparam logic [7:0] REG_ADDR_LO    = 8'h63;
  localparam logic [7:0] REG_COUNT_HI   = 8'h00;
  localparam logic [7:0] REG_COUNT_LO   = 8'h01;
  localparam logic [7:0] RSP_BYTE_COUNT = 8'h02;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int HEADER_BYTES       = 5;
  localparam int HEADER_IDX_W       = 3;
  localparam int MIN_RESPONSE_BYTES = 7;

  // frame positions
  localparam int FRAME_IDX_W = 3;
  localparam logic [FRAME_IDX_W-1:0] FR_ADDR     = 3'd0;
  localparam logic [FRAME_IDX_W-1:0] FR_FUNC     = 3'd1;
  localparam logic [FRAME_IDX_W-1:0] FR_REG_HI   = 3'd2;
  localparam logic [FRAME_IDX_W-1:0] FR_REG_LO   = 3'd3;
  localparam logic [FRAME_IDX_W-1:0] FR_CNT_HI   = 3'd4;
  localparam logic [FRAME_IDX_W-1:0] FR_CNT_LO   = 3'd5;
  localparam logic [FRAME_IDX_W-1:0] FR_CRC_LO   = 3'd6;
  localparam logic [FRAME_IDX_W-1:0] FR_CRC_HI   = 3'd7;

  localparam int LEVEL_BOUNDS = 18;
  localparam logic [4:0] LEVEL_MAX = 5'd17;
  localparam logic [15:0] LEVEL_UPPER [LEVEL_BOUNDS] = '{
    16'd200,   16'd1500,  16'd3300,  16'd5400,  16'd7900,  16'd10700,
    16'd13800, 16'd17100, 16'd20700, 16'd24400, 16'd28400, 16'd32600,
    16'd36900, 16'd41400, 16'd46100, 16'd50900, 16'd56000, 16'd61200
  };

  // Work queued from the front to the back
  typedef struct packed {
    logic        report;
    status_t     status;
    logic [15:0] speed;
  } cmd_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [4:0] speed_level(input logic [15:0] speed);
    logic [4:0] n;
    n = 5'd0;
    for (int k = 0; k < LEVEL_BOUNDS; k++) begin
      if (LEVEL_UPPER[k] < speed) begin
        n = n + 5'd1;
      end
    end
    return (n > LEVEL_MAX) ? LEVEL_MAX : n;
  endfunction

endpackage

// ===== rtl/core/msp_if.sv =====
// ----------------------------------------------------------------------------
// msp_if
// Valid/ready channels of the sensor poll engine: item in, result out.
// ----------------------------------------------------------------------------
interface msp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;

  modport source (output valid, action, rx_byte, input ready);
  modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface msp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [1:0]  status;
  logic [15:0] speed_raw;
  logic [4:0]  beaufort_level;

  modport source (output valid, kind, tx_byte, last, status, speed_raw, beaufort_level,
                  input ready);
  modport sink   (input valid, kind, tx_byte, last, status, speed_raw, beaufort_level,
                  output ready);
endinterface

// ===== rtl/core/modbus_sensor_poll_engine_unit.sv =====
// ----------------------------------------------------------------------------
// modbus_sensor_poll_engine_unit
// Modbus RTU master polling one wind sensor holding register.
// An accepted start or end item is written into the command queue; the back
// end then takes it from there and registers its first result word.
// Throughput: one item per cycle while the command queue has room; a start
// poll yields eight frame bytes, an end of response one report, a byte none.
// The command queue between front and back sets how far items run ahead.
// Reset: synchronous; clears byte count, queue and output; address reads 1.
// ----------------------------------------------------------------------------
module modbus_sensor_poll_engine_unit
  import msp_pkg::*;
#(
  parameter int RX_BUFFER_BYTES = RX_BUFFER_BYTES_DEF,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  msp_in_if.sink     item,
  msp_out_if.source  result
);

  logic [7:0] device_address;
  logic       push_valid;
  logic       push_ready;
  cmd_t       push_cmd;
  logic       cmd_valid;
  logic       cmd_ready;
  cmd_t       cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'd1;
    end else if (cfg_wr_en) begin
      device_address <= cfg_wr_data;
    end
  end

  msp_front #(
    .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .item           (item),
    .device_address (device_address),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_cmd       (push_cmd)
  );

  msp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_cmd),
    .out_valid (cmd_valid),
    .out_ready (cmd_ready),
    .out_data  (cmd)
  );

  msp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .device_address (device_address),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd),
    .result         (result)
  );

endmodule

// ===== rtl/core/msp_front.sv =====
// ----------------------------------------------------------------------------
// msp_front
// Accepts items, counts received bytes and keeps the first five, classifies the
// response and queues frame and report work for the back end.
// ----------------------------------------------------------------------------
module msp_front
  import msp_pkg::*;
#(
  parameter int RX_BUFFER_BYTES = RX_BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  msp_in_if.sink     item,
  input  logic [7:0] device_address,
  output logic       push_valid,
  input  logic       push_ready,
  output cmd_t       push_cmd
);

  localparam int CNT_W = $clog2(RX_BUFFER_BYTES + 1);

  logic [CNT_W-1:0] rx_count;
  logic [7:0]       rx_header [HEADER_BYTES];
  logic             accept;
  action_t          act;

  assign act        = action_t'(item.action);
  assign item.ready = push_ready;
  assign accept     = item.valid && item.ready;
  assign push_valid = accept && (act == ACT_START || act == ACT_END);

  always_comb begin
    push_cmd        = '0;
    push_cmd.report = (act == ACT_END);
    push_cmd.status = ST_OK;
    if (act == ACT_END) begin
      if (rx_count < CNT_W'(MIN_RESPONSE_BYTES)) begin
        push_cmd.status = ST_SHORT;
      end else if (rx_header[0] != device_address || rx_header[1] != FUNC_READ_HOLD ||
                   rx_header[2] != RSP_BYTE_COUNT) begin
        push_cmd.status = ST_HEADER;
      end else begin
        push_cmd.speed = {rx_header[3], rx_header[4]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count <= '0;
    end else if (accept) begin
      case (act)
        ACT_START, ACT_END: rx_count <= '0;
        ACT_BYTE: begin
          // saturate at the buffer size
          if (rx_count < CNT_W'(RX_BUFFER_BYTES)) begin
            rx_count <= rx_count + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && act == ACT_BYTE && rx_count < CNT_W'(HEADER_BYTES)) begin
      rx_header[rx_count[HEADER_IDX_W-1:0]] <= item.rx_byte;
    end
  end

endmodule

// ===== rtl/core/msp_fifo.sv =====
// ----------------------------------------------------------------------------
// msp_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module msp_fifo
  import msp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

endmodule

// ===== rtl/core/msp_back.sv =====
// ----------------------------------------------------------------------------
// msp_back
// Expands queued work into request frame bytes with a running CRC, or into
// one reading report, through a registered output stage.
// ----------------------------------------------------------------------------
module msp_back
  import msp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] device_address,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  msp_out_if.source  result
);

  logic                   load;
  logic                   busy;
  logic [FRAME_IDX_W-1:0] idx;
  logic [15:0]            crc;
  logic [7:0]             frame_byte;

  logic        out_valid;
  logic        out_kind;
  logic [7:0]  out_tx_byte;
  logic        out_last;
  logic [1:0]  out_status;
  logic [15:0] out_speed;
  logic [4:0]  out_level;

  assign load      = !out_valid || result.ready;
  assign cmd_ready = load && !busy;

  always_comb begin
    case (idx)
      FR_ADDR:   frame_byte = device_address;
      FR_FUNC:   frame_byte = FUNC_READ_HOLD;
      FR_REG_HI: frame_byte = REG_ADDR_HI;
      FR_REG_LO: frame_byte = REG_ADDR_LO;
      FR_CNT_HI: frame_byte = REG_COUNT_HI;
      FR_CNT_LO: frame_byte = REG_COUNT_LO;
      FR_CRC_LO: frame_byte = crc[7:0];
      FR_CRC_HI: frame_byte = crc[15:8];
      default:   frame_byte = device_address;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      if (busy) begin
        out_valid <= 1'b1;
        idx       <= idx + FRAME_IDX_W'(1);
        if (idx == FR_CRC_HI) begin
          busy <= 1'b0;
        end
      end else if (cmd_valid) begin
        out_valid <= 1'b1;
        if (!cmd.report) begin
          busy <= 1'b1;
          idx  <= FR_FUNC;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (busy) begin
        out_kind    <= KIND_TX;
        out_tx_byte <= frame_byte;
        out_last    <= (idx == FR_CRC_HI);
        out_status  <= ST_OK;
        out_speed   <= '0;
        out_level   <= '0;
        // the CRC covers the six header bytes only
        if (idx < FR_CRC_LO) begin
          crc <= crc_feed(crc, frame_byte);
        end
      end else if (cmd_valid) begin
        if (cmd.report) begin
          out_kind    <= KIND_REPORT;
          out_tx_byte <= '0;
          out_last    <= 1'b1;
          out_status  <= cmd.status;
          out_speed   <= cmd.speed;
          out_level   <= (cmd.status == ST_OK) ? speed_level(cmd.speed) : 5'd0;
        end else begin
          out_kind    <= KIND_TX;
          out_tx_byte <= device_address;
          out_last    <= 1'b0;
          out_status  <= ST_OK;
          out_speed   <= '0;
          out_level   <= '0;
          crc         <= crc_feed(CRC_INIT, device_address);
        end
      end
    end
  end

  assign result.valid          = out_valid;
  assign result.kind           = out_kind;
  assign result.tx_byte        = out_tx_byte;
  assign result.last           = out_last;
  assign result.status         = out_status;
  assign result.speed_raw      = out_speed;
  assign result.beaufort_level = out_level;

endmodule
